/* rtl/skro_pkg.sv */
// Shared types and constants for the six-key rollover slot table.
// Holds the item and result structs and the controller-to-datapath commands.
// No dependencies.
package skro_pkg;

    localparam int SLOT_COUNT_DEF = 6;
    localparam int SHOWN_SLOTS    = 6;
    localparam int CODE_W         = 8;
    localparam int COUNT_W        = 8;

    // Input operation codes
    localparam logic OP_PRESS   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DIVERT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [CODE_W-1:0] key_code;
        logic              leader_active;
    } t_item;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] slot_code_0;
        logic [CODE_W-1:0] slot_code_1;
        logic [CODE_W-1:0] slot_code_2;
        logic [CODE_W-1:0] slot_code_3;
        logic [CODE_W-1:0] slot_code_4;
        logic [CODE_W-1:0] slot_code_5;
        logic [CODE_W-1:0] diverted_code;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_DIVERT,
        CMD_PRESS_CLEAR,
        CMD_PRESS_NEW,
        CMD_RELEASE,
        CMD_RESTORE
    } t_cmd;

    typedef struct packed {
        logic code_zero;
        logic release_op;
        logic leader;
        logic hit_any;
        logic free_any;
    } t_dp_status;

endpackage

/* rtl/skro_ctrl.sv */
// Sequencing controller for the slot table.
// Decides the command for each item from datapath status; uses skro_pkg.
module skro_ctrl import skro_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RESTORE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Pick the next state and the command for this cycle
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_EVAL;
                    n_busy  = 1'b1;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
                if (!i_status.code_zero) begin
                    if (i_status.release_op) begin
                        o_cmd = CMD_RELEASE;
                    end else if (i_status.leader) begin
                        o_cmd = CMD_DIVERT;
                    end else if (i_status.hit_any) begin
                        o_cmd   = CMD_PRESS_CLEAR;
                        n_state = ST_RESTORE;
                        n_busy  = 1'b1;
                    end else if (i_status.free_any) begin
                        o_cmd = CMD_PRESS_NEW;
                    end
                end
            end
            ST_RESTORE: begin
                o_cmd   = CMD_RESTORE;
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // Hold state and the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

/* rtl/skro_datapath.sv */
// Slot table datapath: code and press-count registers, searches, result register.
// Executes one command per cycle from skro_ctrl; uses skro_pkg.
module skro_datapath import skro_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_cmd       i_cmd,
    output t_dp_status o_status,
    output logic       o_strobe,
    output t_result    o_result
);

    localparam int PAD = (SLOT_COUNT > SHOWN_SLOTS) ? SLOT_COUNT : SHOWN_SLOTS;

    t_item              r_item;
    logic [CODE_W-1:0]  r_code  [SLOT_COUNT];
    logic [COUNT_W-1:0] r_count [SLOT_COUNT];
    logic [CODE_W-1:0]  n_code  [SLOT_COUNT];
    logic [COUNT_W-1:0] n_count [SLOT_COUNT];
    logic [CODE_W-1:0]  show    [PAD];
    logic               r_strobe, n_strobe;
    t_result            r_result, n_result;

    logic [SLOT_COUNT-1:0] match, empty, one;
    logic [SLOT_COUNT-1:0] hit_sel, free_sel, dec_sel, clr_sel;

    // Compare every slot; pick the highest match, free slot and count-one slot
    always_comb begin
        logic seen_match, seen_empty, seen_one;
        seen_match = 1'b0;
        seen_empty = 1'b0;
        seen_one   = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            match[i] = (r_code[i] == r_item.key_code);
            empty[i] = (r_code[i] == '0);
            one[i]   = match[i] && (r_count[i] == COUNT_W'(1));
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            hit_sel[i]  = match[i] && !seen_match;
            free_sel[i] = empty[i] && !seen_empty;
            dec_sel[i]  = match[i] && !seen_one;
            clr_sel[i]  = one[i] && !seen_one;
            seen_match  = seen_match | match[i];
            seen_empty  = seen_empty | empty[i];
            seen_one    = seen_one | one[i];
        end
    end

    assign o_status.code_zero  = (r_item.key_code == '0);
    assign o_status.release_op = (r_item.operation == OP_RELEASE);
    assign o_status.leader     = r_item.leader_active;
    assign o_status.hit_any    = |match;
    assign o_status.free_any   = |empty;

    // Apply the command to the table and build the report
    always_comb begin
        n_strobe = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_code[i]  = r_code[i];
            n_count[i] = r_count[i];
        end
        for (int j = 0; j < PAD; j++) begin
            show[j] = '0;
        end
        case (i_cmd)
            CMD_PRESS_NEW: begin
                n_strobe = 1'b1;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (free_sel[i]) begin
                        n_code[i]  = r_item.key_code;
                        n_count[i] = r_count[i] + COUNT_W'(1);
                    end
                end
            end
            CMD_RELEASE: begin
                n_strobe = |one;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (dec_sel[i]) begin
                        n_count[i] = r_count[i] - COUNT_W'(1);
                    end
                    if (clr_sel[i]) begin
                        n_code[i] = '0;
                    end
                end
            end
            CMD_RESTORE: begin
                n_strobe = 1'b1;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (hit_sel[i]) begin
                        n_count[i] = r_count[i] + COUNT_W'(1);
                    end
                end
            end
            CMD_DIVERT, CMD_PRESS_CLEAR: begin
                n_strobe = 1'b1;
            end
            default: ;
        endcase
        // Report the updated table; a repeated press first shows its slot empty
        for (int i = 0; i < SLOT_COUNT; i++) begin
            show[i] = (i_cmd == CMD_PRESS_CLEAR && hit_sel[i]) ? '0 : n_code[i];
        end
        n_result.kind          = (i_cmd == CMD_DIVERT) ? KIND_DIVERT : KIND_REPORT;
        n_result.slot_code_0   = show[0];
        n_result.slot_code_1   = show[1];
        n_result.slot_code_2   = show[2];
        n_result.slot_code_3   = show[3];
        n_result.slot_code_4   = show[4];
        n_result.slot_code_5   = show[5];
        n_result.diverted_code = (i_cmd == CMD_DIVERT) ? r_item.key_code : '0;
        n_result.last          = (i_cmd != CMD_PRESS_CLEAR);
    end

    // Hold the table and the strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_code[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_strobe <= n_strobe;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_code[i]  <= n_code[i];
                r_count[i] <= n_count[i];
            end
        end
    end

    // Capture the item and the result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_clear_has_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_PRESS_CLEAR |-> $onehot(hit_sel))
        else $error("repeated press without a matching slot");

    a_new_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_PRESS_NEW |-> $onehot(free_sel))
        else $error("new press without a free slot");

    a_clear_then_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_PRESS_CLEAR |=> i_cmd == CMD_RESTORE)
        else $error("cleared report not followed by restore");

    a_first_then_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_result.last |=> r_strobe && r_result.last)
        else $error("first of two reports not followed by final report");

endmodule

/* rtl/six_key_rollover_slot_table_unit.sv */
// Six-key rollover slot table for a boot keyboard report.
//
// Input: raise start with i_item (operation, key_code, leader_active); the
// transfer happens at the edge where start is high and busy is low. busy rises
// the cycle after and stays high while the item is worked on.
// Output: each result sits on o_result for one cycle, flagged by o_strobe, and
// is taken at the end of that cycle; the receiver cannot stall the block.
// Timing: the controller evaluates each item in its evaluate state, so busy is high
// for one cycle; the result is on the ports in the cycle after that. A new item
// is taken once busy is low, so it can enter while the previous result is shown.
// A repeated press adds a restore state: busy stays high through it, and its two
// reports come on consecutive cycles, the second with last set. Code zero, a new
// press on a full table and a release not reaching zero produce no strobe.
// Reset: synchronous active-low i_rst_n empties all slots, zeroes the press
// counters and returns the controller to idle.
module six_key_rollover_slot_table_unit import skro_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_cmd       cmd;
    t_dp_status status;

    // Sequence each item
    skro_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the slot table and drive results
    skro_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* dv/six_key_rollover_slot_table_unit_tb.sv */
// Self-checking testbench for the six-key rollover slot table unit.
// Depends on rtl/skro_pkg.sv and rtl/six_key_rollover_slot_table_unit.sv.
// Key events go in through start/busy; every strobed report is checked against a local model.
`timescale 1ns / 100ps

module six_key_rollover_slot_table_unit_tb;
    import skro_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int N_FIELDS     = 9;

    typedef logic [7:0] t_field_row [N_FIELDS];

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Local copy of the slot table and the reports it should produce
    logic [7:0] table_code  [SLOTS] = '{default: '0};
    logic [7:0] table_count [SLOTS] = '{default: '0};
    t_result    expected_reports [$];

    int mismatch_count = 0;
    int n_transfers    = 0;
    int n_reports      = 0;
    int n_diverted     = 0;
    int n_repeat_pairs = 0;
    int cycle_count    = 0;

    six_key_rollover_slot_table_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Build a report from the current table contents
    function automatic t_result snapshot(input logic kind, input logic [7:0] div,
                                         input logic fin);
        t_result r;
        r.kind          = kind;
        r.slot_code_0   = table_code[0];
        r.slot_code_1   = table_code[1];
        r.slot_code_2   = table_code[2];
        r.slot_code_3   = table_code[3];
        r.slot_code_4   = table_code[4];
        r.slot_code_5   = table_code[5];
        r.diverted_code = div;
        r.last          = fin;
        return r;
    endfunction

    // Update the table for one key event and queue the reports it causes
    function automatic void apply_key_event(input t_item it);
        int i;
        if (it.key_code == 8'd0)
            return;
        if (it.operation == OP_PRESS) begin
            if (it.leader_active) begin
                expected_reports.push_back(snapshot(KIND_DIVERT, it.key_code, 1'b1));
                return;
            end
            // A held code is cleared, reported, then restored and reported again
            for (i = SLOTS - 1; i >= 0; i--) begin
                if (table_code[i] == it.key_code) begin
                    table_code[i] = 8'd0;
                    expected_reports.push_back(snapshot(KIND_REPORT, 8'd0, 1'b0));
                    table_code[i]  = it.key_code;
                    table_count[i] = table_count[i] + 8'd1;
                    expected_reports.push_back(snapshot(KIND_REPORT, 8'd0, 1'b1));
                    return;
                end
            end
            // New code goes into the highest free slot; a full table drops it
            for (i = SLOTS - 1; i >= 0; i--) begin
                if (table_code[i] == 8'd0) begin
                    table_code[i]  = it.key_code;
                    table_count[i] = table_count[i] + 8'd1;
                    expected_reports.push_back(snapshot(KIND_REPORT, 8'd0, 1'b1));
                    return;
                end
            end
            return;
        end
        // Release: decrement matches from the top, clear the first that hits zero
        for (i = SLOTS - 1; i >= 0; i--) begin
            if (table_code[i] == it.key_code) begin
                table_count[i] = table_count[i] - 8'd1;
                if (table_count[i] == 8'd0) begin
                    table_code[i] = 8'd0;
                    expected_reports.push_back(snapshot(KIND_REPORT, 8'd0, 1'b1));
                    return;
                end
            end
        end
    endfunction

    function automatic t_field_row split_fields(input t_result r);
        return '{{7'd0, r.kind}, r.slot_code_0, r.slot_code_1, r.slot_code_2,
                 r.slot_code_3, r.slot_code_4, r.slot_code_5, r.diverted_code,
                 {7'd0, r.last}};
    endfunction

    function automatic string field_name(input int idx);
        case (idx)
            0:       return "kind";
            7:       return "diverted_code";
            8:       return "last";
            default: return $sformatf("slot_code_%0d", idx - 1);
        endcase
    endfunction

    // Check every strobed report against the oldest expected one
    always @(posedge i_clk) begin : check_reports
        t_result    want;
        t_field_row want_f;
        t_field_row got_f;
        int         k;
        if (i_rst_n && o_strobe) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 30)
                    $display("%0t: unexpected report, expected none, actual %h",
                             $time, o_result);
            end else begin
                want   = expected_reports.pop_front();
                want_f = split_fields(want);
                got_f  = split_fields(o_result);
                n_reports++;
                if (want.kind == KIND_DIVERT)
                    n_diverted++;
                if (want.last == 1'b0)
                    n_repeat_pairs++;
                for (k = 0; k < N_FIELDS; k++) begin
                    if (got_f[k] !== want_f[k]) begin
                        mismatch_count++;
                        if (mismatch_count <= 30)
                            $display("%0t: %s mismatch, expected %h, actual %h",
                                     $time, field_name(k), want_f[k], got_f[k]);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d reports outstanding",
                     $time, cycle_count, expected_reports.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one key event and hold it until the transfer happens
    task automatic transfer_key_event(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        apply_key_event(it);
        n_transfers++;
    endtask

    // Drop start and drive noise on the item bus during a gap
    task automatic hold_off(input int n);
        if (n > 0) begin
            start  <= 1'b0;
            i_item <= t_item'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_key(input logic op, input logic [7:0] code, input logic leader,
                            input int gap);
        t_item it;
        it.operation     = op;
        it.key_code      = code;
        it.leader_active = leader;
        transfer_key_event(it);
        hold_off(gap);
    endtask

    // Hold the sender until all reports are in, then let the block settle
    task automatic wait_for_reports();
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Code zero, leader diverts, new and repeated presses, full table, releases
    task automatic test_directed_cases();
        send_key(OP_PRESS,   8'h00, 1'b0, 0);
        send_key(OP_RELEASE, 8'h00, 1'b1, 1);
        send_key(OP_PRESS,   8'hFF, 1'b1, 0);
        send_key(OP_PRESS,   8'h01, 1'b0, 0);
        send_key(OP_PRESS,   8'h80, 1'b0, 2);
        send_key(OP_PRESS,   8'hFF, 1'b0, 0);
        send_key(OP_PRESS,   8'h80, 1'b0, 0);
        send_key(OP_RELEASE, 8'h80, 1'b0, 1);
        send_key(OP_RELEASE, 8'h42, 1'b0, 0);
        send_key(OP_PRESS,   8'h7F, 1'b0, 0);
        send_key(OP_PRESS,   8'hAA, 1'b0, 3);
        send_key(OP_PRESS,   8'h55, 1'b0, 0);
        send_key(OP_PRESS,   8'h33, 1'b0, 0);
        send_key(OP_PRESS,   8'h33, 1'b1, 0);
        send_key(OP_RELEASE, 8'h80, 1'b1, 0);
        send_key(OP_PRESS,   8'h33, 1'b0, 1);
        send_key(OP_RELEASE, 8'h01, 1'b0, 0);
        send_key(OP_RELEASE, 8'hFF, 1'b0, 0);
        send_key(OP_PRESS,   8'hFE, 1'b0, 0);
        send_key(OP_PRESS,   8'h01, 1'b0, 0);
        send_key(OP_RELEASE, 8'h7F, 1'b0, 2);
        send_key(OP_RELEASE, 8'hAA, 1'b0, 0);
        send_key(OP_RELEASE, 8'h55, 1'b0, 0);
        wait_for_reports();
    endtask

    // Press one code until its counter wraps to zero, then release through the wrap
    task automatic test_counter_wrap();
        logic [7:0] code;
        int         held;
        int         s;
        code = (table_code[0] != 8'd0) ? table_code[0] : 8'h5A;
        do begin
            send_key(OP_PRESS, code, 1'b0, $urandom_range(0, 1));
            held = -1;
            for (s = 0; s < SLOTS; s++)
                if (table_code[s] == code)
                    held = s;
        end while (held >= 0 && table_count[held] != 8'd0);
        send_key(OP_RELEASE, code, 1'b0, 0);
        send_key(OP_PRESS,   code, 1'b0, 2);
        wait_for_reports();
    endtask

    // Random presses and releases over a small code pool, with noise mixed in
    task automatic test_random_traffic(input int n_items);
        logic [7:0] pool [12];
        logic       op;
        logic [7:0] code;
        logic       leader;
        int         roll;
        int         burst_left;
        int         i;
        int         s;
        for (i = 0; i < 12; i++)
            pool[i] = 8'($urandom_range(1, 255));
        burst_left = 0;
        for (i = 0; i < n_items; i++) begin
            if (i % 150 == 149)
                wait_for_reports();
            roll   = $urandom_range(0, 99);
            leader = ($urandom_range(0, 9) == 0);
            if (roll < 45) begin
                op   = OP_PRESS;
                code = pool[$urandom_range(0, 11)];
            end else if (roll < 85) begin
                // Release mostly held codes
                op   = OP_RELEASE;
                s    = $urandom_range(0, SLOTS - 1);
                code = (table_code[s] != 8'd0) ? table_code[s] : pool[$urandom_range(0, 11)];
            end else if (roll < 94) begin
                op   = 1'($urandom_range(0, 1));
                code = 8'($urandom_range(0, 255));
            end else begin
                op   = 1'($urandom_range(0, 1));
                code = 8'd0;
            end
            // Occasional back-to-back bursts
            if (burst_left == 0 && $urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 30);
            if (burst_left > 0) begin
                burst_left--;
                send_key(op, code, leader, 0);
            end else begin
                send_key(op, code, leader, pick_gap());
            end
        end
        wait_for_reports();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_counter_wrap();
        test_random_traffic(680);
        $display("Ran %0d key event transfers; checked %0d reports", n_transfers, n_reports);
        $display("including %0d leader diverts and %0d repeated-press pairs",
                 n_diverted, n_repeat_pairs);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
